@@ design/hsrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsrc_pkg
// Shared codes, literal tables and result type for the seed request classifier.
// ----------------------------------------------------------------------------
package hsrc_pkg;

  localparam int MaxRequestBytes = 4096;
  localparam int SpaceWindow     = 24;
  localparam int RootChars       = 39;
  localparam int PathBits        = 5 * RootChars;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_OURS   = 2'd1;
  localparam logic [1:0] ST_BAD_METHOD = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  localparam logic [3:0] P_METHOD     = 4'd0;
  localparam logic [3:0] P_OTHER_SEED = 4'd1;
  localparam logic [3:0] P_PREFIX     = 4'd2;
  localparam logic [3:0] P_PATH       = 4'd3;
  localparam logic [3:0] P_QUERY      = 4'd4;
  localparam logic [3:0] P_VERSION    = 4'd5;
  localparam logic [3:0] P_NAME       = 4'd6;
  localparam logic [3:0] P_VALUE      = 4'd7;
  localparam logic [3:0] P_DONE       = 4'd8;
  localparam logic [3:0] P_SKIP       = 4'd9;

  localparam int F_GET_DEAD  = 0;
  localparam int F_HEAD_DEAD = 1;
  localparam int F_HEAD      = 2;
  localparam int F_NUL       = 3;
  localparam int F_INM       = 4;
  localparam int F_LINE_HIT  = 5;
  localparam int F_CR        = 6;
  localparam int F_TRAIL     = 7;

  localparam logic [1:0] K_NONE  = 2'd0;
  localparam logic [1:0] K_RANGE = 2'd1;
  localparam logic [1:0] K_INM   = 2'd2;

  localparam logic [2:0] R_LEAD = 3'd0;
  localparam logic [2:0] R_PFX  = 3'd1;
  localparam logic [2:0] R_LO   = 3'd2;
  localparam logic [2:0] R_HI   = 3'd3;
  localparam logic [2:0] R_BAD  = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam int OutBits  = 2 + 1 + 1 + 64 * 5;
  localparam int OutBytes = (OutBits + 7) / 8;

  typedef struct packed {
    logic [1:0]   status;
    logic         head_only;
    logic         none_match_hit;
    logic [63:0]  range_first;
    logic [63:0]  range_last;
    logic [191:0] root;
  } hsrc_result_t;

  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] data;
  } hsrc_byte_t;

  function automatic logic [7:0] get_ch(input logic [2:0] i);
    case (i)
      3'd0:    get_ch = "G";
      3'd1:    get_ch = "E";
      3'd2:    get_ch = "T";
      default: get_ch = " ";
    endcase
  endfunction

  function automatic logic [7:0] head_ch(input logic [2:0] i);
    case (i)
      3'd0:    head_ch = "H";
      3'd1:    head_ch = "E";
      3'd2:    head_ch = "A";
      3'd3:    head_ch = "D";
      default: head_ch = " ";
    endcase
  endfunction

  function automatic logic [7:0] seed_ch(input logic [2:0] i);
    case (i)
      3'd1:    seed_ch = "s";
      3'd2:    seed_ch = "e";
      3'd3:    seed_ch = "e";
      3'd4:    seed_ch = "d";
      default: seed_ch = "/";
    endcase
  endfunction

  function automatic logic [7:0] ver_ch(input logic [2:0] i);
    case (i)
      3'd0:    ver_ch = " ";
      3'd1:    ver_ch = "H";
      3'd2:    ver_ch = "T";
      3'd3:    ver_ch = "T";
      3'd4:    ver_ch = "P";
      3'd5:    ver_ch = "/";
      3'd6:    ver_ch = "1";
      default: ver_ch = ".";
    endcase
  endfunction

  function automatic logic [7:0] bytes_ch(input logic [2:0] i);
    case (i)
      3'd0:    bytes_ch = "b";
      3'd1:    bytes_ch = "y";
      3'd2:    bytes_ch = "t";
      3'd3:    bytes_ch = "e";
      3'd4:    bytes_ch = "s";
      default: bytes_ch = "=";
    endcase
  endfunction

  function automatic logic [7:0] range_ch(input logic [2:0] i);
    case (i)
      3'd0:    range_ch = "r";
      3'd1:    range_ch = "a";
      3'd2:    range_ch = "n";
      3'd3:    range_ch = "g";
      default: range_ch = "e";
    endcase
  endfunction

  function automatic logic [7:0] inm_ch(input logic [3:0] i);
    case (i)
      4'd0:    inm_ch = "i";
      4'd1:    inm_ch = "f";
      4'd2:    inm_ch = "-";
      4'd3:    inm_ch = "n";
      4'd4:    inm_ch = "o";
      4'd5:    inm_ch = "n";
      4'd6:    inm_ch = "e";
      4'd7:    inm_ch = "-";
      4'd8:    inm_ch = "m";
      4'd9:    inm_ch = "a";
      4'd10:   inm_ch = "t";
      4'd11:   inm_ch = "c";
      default: inm_ch = "h";
    endcase
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] b32_char(input logic [4:0] v);
    b32_char = (v < 5'd26) ? 8'("A") + {3'd0, v} : 8'("2") + {3'd0, v} - 8'd26;
  endfunction

endpackage

@@ design/hsrc_digit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsrc_digit
// Decimal accumulate step: acc * 10 + d with a 64-bit overflow flag.
// ----------------------------------------------------------------------------
module hsrc_digit (
  input  logic [63:0] acc,
  input  logic [3:0]  digit,
  output logic [63:0] sum,
  output logic        fits
);

  logic [67:0] wide;

  // times ten as two shifted adds
  assign wide = {1'b0, acc, 3'd0} + {3'd0, acc, 1'b0} + {64'd0, digit};
  assign sum  = wide[63:0];
  assign fits = (wide[67:64] == 4'd0);

endmodule

@@ design/hsrc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsrc_parser
// Per-byte request parser state and the result formed on the final byte.
// ----------------------------------------------------------------------------
module hsrc_parser #(
  parameter int MAX_REQUEST_BYTES = hsrc_pkg::MaxRequestBytes
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hsrc_pkg::hsrc_byte_t in_byte,
  output hsrc_pkg::hsrc_result_t result
);

  localparam int BcW = $clog2(MAX_REQUEST_BYTES + 2);
  localparam logic [BcW-1:0] BcMax = BcW'(MAX_REQUEST_BYTES);
  localparam int PB = hsrc_pkg::PathBits;

  logic [BcW-1:0] byte_count, byte_count_next;
  logic [3:0]     phase, phase_next;
  logic [5:0]     lit, lit_next;
  logic [5:0]     tag_pos, tag_pos_next;
  logic [63:0]    low_accum, low_accum_next;
  logic [63:0]    high_accum, high_accum_next;
  logic [63:0]    kept_first, kept_first_next;
  logic [63:0]    kept_last, kept_last_next;
  logic [7:0]     flags, flags_next;
  logic [1:0]     outcome, outcome_next;
  logic [1:0]     hdr_kind, hdr_kind_next;
  logic           range_dead, range_dead_next;
  logic           inm_dead, inm_dead_next;
  logic [2:0]     rng, rng_next;
  logic           lo_any, lo_any_next;
  logic           hi_any, hi_any_next;
  logic [1:0]     star, star_next;
  logic [PB-1:0]  path;
  logic [PB-1:0]  tag_rot;
  logic           path_push, tag_adv;
  logic [4:0]     path_sym;

  logic [63:0] lo_sum, hi_sum;
  logic        lo_fits, hi_fits;
  logic [7:0]  c;
  logic [3:0]  dval;
  logic        is_digit;
  logic        got;
  logic        b32_ok;
  logic [4:0]  b32_v;
  logic [7:0]  want;
  logic [7:0]  lc;
  logic [1:0]  st;

  assign c        = in_byte.data;
  assign lc       = hsrc_pkg::to_lower(c);
  assign is_digit = (c >= "0") && (c <= "9");
  assign dval     = c[3:0];

  hsrc_digit u_lo (.acc(low_accum),  .digit(dval), .sum(lo_sum), .fits(lo_fits));
  hsrc_digit u_hi (.acc(high_accum), .digit(dval), .sum(hi_sum), .fits(hi_fits));

  always_comb begin
    b32_ok = 1'b1;
    b32_v  = 5'd0;
    if (c >= "A" && c <= "Z") begin
      b32_v = 5'(c - 8'("A"));
    end else if (c >= "2" && c <= "7") begin
      b32_v = 5'(c - 8'("2") + 8'd26);
    end else begin
      b32_ok = 1'b0;
    end
  end

  always_comb begin
    byte_count_next = byte_count;
    phase_next      = phase;
    lit_next        = lit;
    tag_pos_next    = tag_pos;
    low_accum_next  = low_accum;
    high_accum_next = high_accum;
    kept_first_next = kept_first;
    kept_last_next  = kept_last;
    flags_next      = flags;
    outcome_next    = outcome;
    hdr_kind_next   = hdr_kind;
    range_dead_next = range_dead;
    inm_dead_next   = inm_dead;
    rng_next        = rng;
    lo_any_next     = lo_any;
    hi_any_next     = hi_any;
    star_next       = star;
    path_push       = 1'b0;
    path_sym        = b32_v;
    tag_adv         = 1'b0;
    got             = 1'b0;
    want            = hsrc_pkg::CH_QUOTE;

    if (byte_count <= BcMax) byte_count_next = byte_count + 1'b1;
    if (c == 8'd0) flags_next[hsrc_pkg::F_NUL] = 1'b1;

    case (phase)
      hsrc_pkg::P_METHOD: begin
        if (!flags[hsrc_pkg::F_GET_DEAD]) begin
          if (byte_count < BcW'(4) && c == hsrc_pkg::get_ch(byte_count[2:0])) begin
            if (byte_count == BcW'(3)) begin
              phase_next = hsrc_pkg::P_PREFIX;
              lit_next   = 6'd0;
              got        = 1'b1;
            end
          end else begin
            flags_next[hsrc_pkg::F_GET_DEAD] = 1'b1;
          end
        end
        if (!got && !flags[hsrc_pkg::F_HEAD_DEAD]) begin
          if (byte_count < BcW'(5) && c == hsrc_pkg::head_ch(byte_count[2:0])) begin
            if (byte_count == BcW'(4)) begin
              flags_next[hsrc_pkg::F_HEAD] = 1'b1;
              phase_next = hsrc_pkg::P_PREFIX;
              lit_next   = 6'd0;
              got        = 1'b1;
            end
          end else begin
            flags_next[hsrc_pkg::F_HEAD_DEAD] = 1'b1;
          end
        end
        if (!got && flags_next[hsrc_pkg::F_GET_DEAD] && flags_next[hsrc_pkg::F_HEAD_DEAD]) begin
          if (c == hsrc_pkg::CH_SP && byte_count < BcW'(hsrc_pkg::SpaceWindow)) begin
            phase_next = hsrc_pkg::P_OTHER_SEED;
            lit_next   = 6'd0;
          end else if (byte_count >= BcW'(hsrc_pkg::SpaceWindow - 1)) begin
            outcome_next = hsrc_pkg::ST_NOT_OURS;
            phase_next   = hsrc_pkg::P_SKIP;
          end
        end
      end
      hsrc_pkg::P_OTHER_SEED, hsrc_pkg::P_PREFIX: begin
        if (lit < 6'd6 && c == hsrc_pkg::seed_ch(lit[2:0])) begin
          lit_next = lit + 6'd1;
          if (lit == 6'd5) begin
            if (phase == hsrc_pkg::P_OTHER_SEED) begin
              outcome_next = hsrc_pkg::ST_BAD_METHOD;
              phase_next   = hsrc_pkg::P_SKIP;
            end else begin
              phase_next = hsrc_pkg::P_PATH;
              lit_next   = 6'd0;
            end
          end
        end else begin
          outcome_next = hsrc_pkg::ST_NOT_OURS;
          phase_next   = hsrc_pkg::P_SKIP;
        end
      end
      hsrc_pkg::P_PATH: begin
        if (c == hsrc_pkg::CH_SP || c == "?" || c == hsrc_pkg::CH_CR || c == hsrc_pkg::CH_LF)
        begin
          if (lit == 6'(hsrc_pkg::RootChars) && c == hsrc_pkg::CH_SP) begin
            phase_next = hsrc_pkg::P_VERSION;
            lit_next   = 6'd1;
          end else if (lit == 6'(hsrc_pkg::RootChars) && c == "?") begin
            phase_next = hsrc_pkg::P_QUERY;
          end else begin
            outcome_next = hsrc_pkg::ST_NOT_FOUND;
            phase_next   = hsrc_pkg::P_SKIP;
          end
        end else if (lit >= 6'(hsrc_pkg::RootChars) || !b32_ok) begin
          outcome_next = hsrc_pkg::ST_NOT_FOUND;
          phase_next   = hsrc_pkg::P_SKIP;
        end else begin
          path_push = 1'b1;
          lit_next  = lit + 6'd1;
        end
      end
      hsrc_pkg::P_QUERY: begin
        if (c == hsrc_pkg::CH_SP) begin
          phase_next = hsrc_pkg::P_VERSION;
          lit_next   = 6'd1;
        end else if (c == hsrc_pkg::CH_CR || c == hsrc_pkg::CH_LF) begin
          outcome_next = hsrc_pkg::ST_NOT_FOUND;
          phase_next   = hsrc_pkg::P_SKIP;
        end
      end
      hsrc_pkg::P_VERSION: begin
        if ((lit < 6'd8 && c == hsrc_pkg::ver_ch(lit[2:0])) ||
            (lit == 6'd8 && (c == "0" || c == "1")) ||
            (lit == 6'd9 && c == hsrc_pkg::CH_CR)) begin
          lit_next = lit + 6'd1;
        end else if (lit == 6'd10 && c == hsrc_pkg::CH_LF) begin
          phase_next      = hsrc_pkg::P_NAME;
          lit_next        = 6'd0;
          range_dead_next = 1'b0;
          inm_dead_next   = 1'b0;
        end else begin
          outcome_next = hsrc_pkg::ST_NOT_FOUND;
          phase_next   = hsrc_pkg::P_SKIP;
        end
      end
      hsrc_pkg::P_NAME: begin
        if (lit == 6'd0 && (c == hsrc_pkg::CH_CR || c == hsrc_pkg::CH_LF)) begin
          phase_next = hsrc_pkg::P_DONE;
        end else if (c == hsrc_pkg::CH_LF) begin
          lit_next        = 6'd0;
          range_dead_next = 1'b0;
          inm_dead_next   = 1'b0;
        end else if (c == ":") begin
          if (lit == 6'd5 && !range_dead) hdr_kind_next = hsrc_pkg::K_RANGE;
          else if (lit == 6'd13 && !inm_dead) hdr_kind_next = hsrc_pkg::K_INM;
          else hdr_kind_next = hsrc_pkg::K_NONE;
          flags_next[hsrc_pkg::F_LINE_HIT] = 1'b0;
          flags_next[hsrc_pkg::F_CR]       = 1'b0;
          flags_next[hsrc_pkg::F_TRAIL]    = 1'b0;
          rng_next        = hsrc_pkg::R_LEAD;
          lo_any_next     = 1'b0;
          hi_any_next     = 1'b0;
          star_next       = 2'd0;
          tag_pos_next    = 6'd0;
          low_accum_next  = 64'd0;
          high_accum_next = 64'd0;
          lit_next        = 6'd0;
          phase_next      = hsrc_pkg::P_VALUE;
        end else begin
          if (lit >= 6'd5 || lc != hsrc_pkg::range_ch(lit[2:0])) range_dead_next = 1'b1;
          if (lit >= 6'd13 || lc != hsrc_pkg::inm_ch(lit[3:0])) inm_dead_next = 1'b1;
          if (lit < 6'd63) lit_next = lit + 6'd1;
        end
      end
      hsrc_pkg::P_VALUE: begin
        if (c == hsrc_pkg::CH_LF) begin
          if (hdr_kind == hsrc_pkg::K_RANGE && rng == hsrc_pkg::R_HI &&
              !(hi_any && high_accum < low_accum)) begin
            kept_first_next = low_accum;
            kept_last_next  = hi_any ? high_accum : '1;
          end else if (hdr_kind == hsrc_pkg::K_INM &&
                       (star == 2'd1 || flags[hsrc_pkg::F_LINE_HIT])) begin
            flags_next[hsrc_pkg::F_INM] = 1'b1;
          end
          phase_next      = hsrc_pkg::P_NAME;
          lit_next        = 6'd0;
          range_dead_next = 1'b0;
          inm_dead_next   = 1'b0;
        end else begin
          // a held CR that is not followed by LF counts as value text
          if (flags[hsrc_pkg::F_CR]) begin
            flags_next[hsrc_pkg::F_CR] = 1'b0;
            if (hdr_kind == hsrc_pkg::K_RANGE) begin
              rng_next = hsrc_pkg::R_BAD;
            end else if (hdr_kind == hsrc_pkg::K_INM) begin
              star_next    = 2'd2;
              tag_pos_next = 6'd0;
            end
          end
          if (c == hsrc_pkg::CH_CR) begin
            flags_next[hsrc_pkg::F_CR] = 1'b1;
          end else if (hdr_kind == hsrc_pkg::K_RANGE) begin
            if (rng_next != hsrc_pkg::R_BAD) begin
              if (c == hsrc_pkg::CH_SP || c == hsrc_pkg::CH_TAB) begin
                if (rng_next != hsrc_pkg::R_LEAD) flags_next[hsrc_pkg::F_TRAIL] = 1'b1;
              end else if (flags[hsrc_pkg::F_TRAIL]) begin
                rng_next = hsrc_pkg::R_BAD;
              end else begin
                case (rng_next)
                  hsrc_pkg::R_LEAD, hsrc_pkg::R_PFX: begin
                    if (rng_next == hsrc_pkg::R_LEAD) lit_next = 6'd0;
                    if (lit_next < 6'd6 && lc == hsrc_pkg::bytes_ch(lit_next[2:0])) begin
                      rng_next = (lit_next == 6'd5) ? hsrc_pkg::R_LO : hsrc_pkg::R_PFX;
                      lit_next = lit_next + 6'd1;
                    end else begin
                      rng_next = hsrc_pkg::R_BAD;
                    end
                  end
                  hsrc_pkg::R_LO: begin
                    if (is_digit) begin
                      if (lo_fits) begin
                        low_accum_next = lo_sum;
                        lo_any_next    = 1'b1;
                      end else begin
                        rng_next = hsrc_pkg::R_BAD;
                      end
                    end else if (c == "-" && lo_any) begin
                      rng_next = hsrc_pkg::R_HI;
                    end else begin
                      rng_next = hsrc_pkg::R_BAD;
                    end
                  end
                  default: begin
                    if (is_digit && hi_fits) begin
                      high_accum_next = hi_sum;
                      hi_any_next     = 1'b1;
                    end else begin
                      rng_next = hsrc_pkg::R_BAD;
                    end
                  end
                endcase
              end
            end
          end else if (hdr_kind == hsrc_pkg::K_INM) begin
            if (c != hsrc_pkg::CH_SP && c != hsrc_pkg::CH_TAB)
              star_next = (star_next == 2'd0 && c == "*") ? 2'd1 : 2'd2;
            if (tag_pos_next != 6'd0 && tag_pos_next <= 6'(hsrc_pkg::RootChars))
              want = hsrc_pkg::b32_char(tag_rot[PB-1 -: 5]);
            if (c == want) begin
              if (tag_pos_next >= 6'(hsrc_pkg::RootChars + 1)) begin
                flags_next[hsrc_pkg::F_LINE_HIT] = 1'b1;
                tag_pos_next = 6'd1;
              end else begin
                tag_adv      = (tag_pos_next != 6'd0);
                tag_pos_next = tag_pos_next + 6'd1;
              end
            end else begin
              tag_pos_next = (c == hsrc_pkg::CH_QUOTE) ? 6'd1 : 6'd0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // final status from the state after this byte
  always_comb begin
    if (flags_next[hsrc_pkg::F_NUL] || byte_count_next > BcMax) begin
      st = hsrc_pkg::ST_NOT_OURS;
    end else begin
      case (phase_next)
        hsrc_pkg::P_METHOD, hsrc_pkg::P_OTHER_SEED, hsrc_pkg::P_PREFIX:
          st = hsrc_pkg::ST_NOT_OURS;
        hsrc_pkg::P_PATH, hsrc_pkg::P_QUERY, hsrc_pkg::P_VERSION:
          st = hsrc_pkg::ST_NOT_FOUND;
        hsrc_pkg::P_NAME, hsrc_pkg::P_VALUE, hsrc_pkg::P_DONE:
          st = hsrc_pkg::ST_OK;
        default:
          st = outcome_next;
      endcase
    end
    result.status         = st;
    result.head_only      = 1'b0;
    result.none_match_hit = 1'b0;
    result.range_first    = 64'd0;
    result.range_last     = '1;
    result.root           = 192'd0;
    if (st == hsrc_pkg::ST_OK) begin
      result.head_only      = flags_next[hsrc_pkg::F_HEAD];
      result.none_match_hit = flags_next[hsrc_pkg::F_INM];
      result.range_first    = kept_first_next;
      result.range_last     = kept_last_next;
      result.root           = path[PB-1 -: 192];
    end
  end

  // first symbol ends up in the top bits; tag_rot rotates with the tag match
  always_ff @(posedge clk) begin
    if (in_byte.step) begin
      if (path_push) path <= {path[PB-6:0], path_sym};
      if (tag_pos_next == 6'd1) tag_rot <= path;
      else if (tag_adv) tag_rot <= {tag_rot[PB-6:0], tag_rot[PB-1 -: 5]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_byte.step && in_byte.last)) begin
      byte_count <= '0;
      phase      <= hsrc_pkg::P_METHOD;
      lit        <= 6'd0;
      tag_pos    <= 6'd0;
      low_accum  <= 64'd0;
      high_accum <= 64'd0;
      kept_first <= 64'd0;
      kept_last  <= '1;
      flags      <= 8'd0;
      outcome    <= hsrc_pkg::ST_OK;
      hdr_kind   <= hsrc_pkg::K_NONE;
      range_dead <= 1'b0;
      inm_dead   <= 1'b0;
      rng        <= hsrc_pkg::R_LEAD;
      lo_any     <= 1'b0;
      hi_any     <= 1'b0;
      star       <= 2'd0;
    end else if (in_byte.step) begin
      byte_count <= byte_count_next;
      phase      <= phase_next;
      lit        <= lit_next;
      tag_pos    <= tag_pos_next;
      low_accum  <= low_accum_next;
      high_accum <= high_accum_next;
      kept_first <= kept_first_next;
      kept_last  <= kept_last_next;
      flags      <= flags_next;
      outcome    <= outcome_next;
      hdr_kind   <= hdr_kind_next;
      range_dead <= range_dead_next;
      inm_dead   <= inm_dead_next;
      rng        <= rng_next;
      lo_any     <= lo_any_next;
      hi_any     <= hi_any_next;
      star       <= star_next;
    end
  end

endmodule

@@ design/http_seed_request_classifier_unit.sv @@
`timescale 1ns / 1ps
// Path: input register, parser, then the result register that sets m_tvalid.
// Throughput: one byte per cycle; the parser handles each byte in a single
// pass between the input register and the result register.
// A result waiting on m_tready stalls only a following final byte.
// Reset: synchronous rst clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
// http_seed_request_classifier_unit
// Streams request bytes in and emits one classification item per request.
// ----------------------------------------------------------------------------
module http_seed_request_classifier_unit #(
  parameter int MAX_REQUEST_BYTES = hsrc_pkg::MaxRequestBytes
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // data_byte
  input  logic                             s_tlast,   // last_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[1:0], head_only[2], none_match_hit[3], range_first[67:4],
  // range_last[131:68], root_word_high[195:132], root_word_mid[259:196],
  // root_word_low[323:260], zero pad
  output logic [8*hsrc_pkg::OutBytes-1:0]  m_tdata
);

  logic                   in_v;
  logic                   in_last;
  logic [7:0]             in_data;
  logic                   advance;
  hsrc_pkg::hsrc_byte_t   pbyte;
  hsrc_pkg::hsrc_result_t res;

  assign advance  = in_v && !(in_last && m_tvalid && !m_tready);
  assign s_tready = !in_v || advance;

  assign pbyte.step = advance;
  assign pbyte.last = in_last;
  assign pbyte.data = in_data;

  hsrc_parser #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_byte (pbyte),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
    if (s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      m_tdata <= {4'd0, res.root[63:0], res.root[127:64], res.root[191:128],
                  res.range_last, res.range_first, res.none_match_hit,
                  res.head_only, res.status};
    end
  end

endmodule

@@ design/hsrc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsrc_checker
// Port-level checks for the seed request classifier, bound to the top level.
// ----------------------------------------------------------------------------
module hsrc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [7:0]                      s_tdata,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [8*hsrc_pkg::OutBytes-1:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a pending result item");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != hsrc_pkg::ST_OK |->
      m_tdata[67:2] == 66'd0 && m_tdata[131:68] == '1 && m_tdata[323:132] == 192'd0)
    else $error("failed request carries payload");

  a_range_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == hsrc_pkg::ST_OK |-> m_tdata[67:4] <= m_tdata[131:68])
    else $error("range first above range last");

endmodule

bind http_seed_request_classifier_unit hsrc_checker u_hsrc_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives HTTP request bytes into the seed request classifier, predicts each
// classification item in a local parser and checks every result field.
// A directed table comes first, then random well-formed and broken requests.
// ----------------------------------------------------------------------------
module testbench;
  import hsrc_pkg::*;

  typedef bit [7:0] u8;

  typedef struct {
    u8  data;
    bit last;
    int fixed_status;  // -1: use the parser prediction
    bit pause;         // wait for all results before this item
  } req_byte_t;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [7:0]               s_tdata;
  logic                     s_tlast;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [8*OutBytes-1:0]    m_tdata;

  http_seed_request_classifier_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  req_byte_t    byte_stream[$];
  hsrc_result_t pending_results[$];
  int           errors = 0;
  int           results_seen = 0;

  string LIT_GET   = "GET ";
  string LIT_HEAD  = "HEAD ";
  string LIT_SEED  = "/seed/";
  string LIT_VER   = " HTTP/1.";
  string LIT_BYTES = "bytes=";
  string LIT_RANGE = "range";
  string LIT_INM   = "if-none-match";

  // parser copy
  int          byte_cnt;
  logic [3:0]  phase;
  int          lit_pos;
  logic [4:0]  root_sym[RootChars];
  int          tag_pos;
  logic [63:0] lo_acc, hi_acc, keep_first, keep_last;
  logic [7:0]  flags;
  logic [1:0]  outc;
  logic [1:0]  hdr_kind;
  bit          range_dead, inm_dead, lo_seen, hi_seen;
  logic [2:0]  rng_st;
  int          star_st;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic u8 lc(u8 c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic int sym_value(u8 c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "2" && c <= "7") return c - "2" + 26;
    return -1;
  endfunction

  function automatic u8 sym_char(logic [4:0] v);
    return (v < 26) ? u8'("A") + v : u8'("2") + v - 8'd26;
  endfunction

  function automatic bit add_dig(inout logic [63:0] acc, input int d);
    logic [63:0] dd;
    dd = d;
    if (acc > ({64{1'b1}} - dd) / 64'd10) return 0;
    acc = acc * 64'd10 + dd;
    return 1;
  endfunction

  task automatic clear_parser();
    byte_cnt = 0; phase = P_METHOD; lit_pos = 0; tag_pos = 0;
    foreach (root_sym[k]) root_sym[k] = 0;
    lo_acc = 0; hi_acc = 0; keep_first = 0; keep_last = '1;
    flags = 0; outc = ST_OK; hdr_kind = K_NONE;
    range_dead = 0; inm_dead = 0; rng_st = R_LEAD;
    lo_seen = 0; hi_seen = 0; star_st = 0;
  endtask

  task automatic end_with(logic [1:0] st);
    outc = st;
    phase = P_SKIP;
  endtask

  task automatic line_start();
    flags[F_LINE_HIT] = 0; flags[F_CR] = 0; flags[F_TRAIL] = 0;
    rng_st = R_LEAD; lo_seen = 0; hi_seen = 0; star_st = 0;
    tag_pos = 0; lo_acc = 0; hi_acc = 0; lit_pos = 0;
  endtask

  task automatic range_in(u8 c);
    bit ws;
    ws = (c == CH_SP || c == CH_TAB);
    if (rng_st == R_BAD) return;
    if (ws) begin
      if (rng_st != R_LEAD) flags[F_TRAIL] = 1;
      return;
    end
    if (flags[F_TRAIL]) begin
      rng_st = R_BAD;
      return;
    end
    if (rng_st == R_LEAD) begin
      rng_st = R_PFX;
      lit_pos = 0;
    end
    if (rng_st == R_PFX) begin
      if (lit_pos < 6 && lc(c) == LIT_BYTES[lit_pos]) begin
        lit_pos++;
        if (lit_pos == 6) rng_st = R_LO;
      end else rng_st = R_BAD;
    end else if (rng_st == R_LO) begin
      if (c >= "0" && c <= "9") begin
        if (add_dig(lo_acc, c - "0")) lo_seen = 1;
        else rng_st = R_BAD;
      end else if (c == "-" && lo_seen) rng_st = R_HI;
      else rng_st = R_BAD;
    end else begin
      if (c >= "0" && c <= "9" && add_dig(hi_acc, c - "0")) hi_seen = 1;
      else rng_st = R_BAD;
    end
  endtask

  task automatic inm_in(u8 c);
    u8 want;
    if (c != CH_SP && c != CH_TAB) star_st = (star_st == 0 && c == "*") ? 1 : 2;
    if (tag_pos == 0 || tag_pos > RootChars) want = CH_QUOTE;
    else want = sym_char(root_sym[(tag_pos - 1) % RootChars]);
    if (c == want) begin
      tag_pos++;
      if (tag_pos >= RootChars + 2) begin
        flags[F_LINE_HIT] = 1;
        tag_pos = 1;
      end
    end else tag_pos = (c == CH_QUOTE) ? 1 : 0;
  endtask

  task automatic value_in(u8 c);
    if (hdr_kind == K_RANGE) range_in(c);
    else if (hdr_kind == K_INM) inm_in(c);
  endtask

  task automatic commit_line();
    if (hdr_kind == K_RANGE && rng_st == R_HI && !(hi_seen && hi_acc < lo_acc)) begin
      keep_first = lo_acc;
      keep_last = hi_seen ? hi_acc : '1;
    end else if (hdr_kind == K_INM && (star_st == 1 || flags[F_LINE_HIT])) begin
      flags[F_INM] = 1;
    end
  endtask

  task automatic method_in(u8 c, int i);
    if (!flags[F_GET_DEAD]) begin
      if (i < 4 && c == LIT_GET[i]) begin
        if (i == 3) begin
          phase = P_PREFIX; lit_pos = 0;
          return;
        end
      end else flags[F_GET_DEAD] = 1;
    end
    if (!flags[F_HEAD_DEAD]) begin
      if (i < 5 && c == LIT_HEAD[i]) begin
        if (i == 4) begin
          flags[F_HEAD] = 1; phase = P_PREFIX; lit_pos = 0;
          return;
        end
      end else flags[F_HEAD_DEAD] = 1;
    end
    if (flags[F_GET_DEAD] && flags[F_HEAD_DEAD]) begin
      if (c == CH_SP && i < SpaceWindow) begin
        phase = P_OTHER_SEED; lit_pos = 0;
      end else if (i + 1 >= SpaceWindow) end_with(ST_NOT_OURS);
    end
  endtask

  task automatic name_in(u8 c);
    int k;
    k = lit_pos;
    if (k == 0 && (c == CH_CR || c == CH_LF)) begin
      phase = P_DONE;
      return;
    end
    if (c == CH_LF) begin
      lit_pos = 0; range_dead = 0; inm_dead = 0;
      return;
    end
    if (c == ":") begin
      if (k == 5 && !range_dead) hdr_kind = K_RANGE;
      else if (k == 13 && !inm_dead) hdr_kind = K_INM;
      else hdr_kind = K_NONE;
      line_start();
      phase = P_VALUE;
      return;
    end
    if (k >= 5 || lc(c) != LIT_RANGE[k]) range_dead = 1;
    if (k >= 13 || lc(c) != LIT_INM[k]) inm_dead = 1;
    if (lit_pos < 63) lit_pos++;
  endtask

  task automatic parse_in(u8 c, int i);
    int k;
    int v;
    k = lit_pos;
    case (phase)
      P_METHOD: method_in(c, i);
      P_OTHER_SEED, P_PREFIX: begin
        if (k < 6 && c == LIT_SEED[k]) begin
          lit_pos++;
          if (lit_pos == 6) begin
            if (phase == P_OTHER_SEED) end_with(ST_BAD_METHOD);
            else begin
              phase = P_PATH; lit_pos = 0;
            end
          end
        end else end_with(ST_NOT_OURS);
      end
      P_PATH: begin
        if (c == CH_SP || c == "?" || c == CH_CR || c == CH_LF) begin
          if (k == RootChars && c == CH_SP) begin
            phase = P_VERSION; lit_pos = 1;
          end else if (k == RootChars && c == "?") phase = P_QUERY;
          else end_with(ST_NOT_FOUND);
        end else begin
          v = sym_value(c);
          if (k >= RootChars || v < 0) end_with(ST_NOT_FOUND);
          else begin
            root_sym[k] = v;
            lit_pos++;
          end
        end
      end
      P_QUERY: begin
        if (c == CH_SP) begin
          phase = P_VERSION; lit_pos = 1;
        end else if (c == CH_CR || c == CH_LF) end_with(ST_NOT_FOUND);
      end
      P_VERSION: begin
        if ((k < 8 && c == LIT_VER[k]) || (k == 8 && (c == "0" || c == "1")) ||
            (k == 9 && c == CH_CR)) lit_pos++;
        else if (k == 10 && c == CH_LF) begin
          phase = P_NAME; lit_pos = 0; range_dead = 0; inm_dead = 0;
        end else end_with(ST_NOT_FOUND);
      end
      P_NAME: name_in(c);
      P_VALUE: begin
        if (c == CH_LF) begin
          commit_line();
          phase = P_NAME; lit_pos = 0; range_dead = 0; inm_dead = 0;
        end else begin
          // a CR not followed by LF counts as a value byte
          if (flags[F_CR]) begin
            flags[F_CR] = 0;
            value_in(CH_CR);
          end
          if (c == CH_CR) flags[F_CR] = 1;
          else value_in(c);
        end
      end
      default: ;
    endcase
  endtask

  function automatic hsrc_result_t reject_result(logic [1:0] st);
    hsrc_result_t r;
    r = '0;
    r.status = st;
    r.range_last = '1;
    return r;
  endfunction

  task automatic classify_byte(u8 c, bit last, int fixed_status);
    int i;
    logic [1:0] st;
    logic [5*RootChars-1:0] full;
    hsrc_result_t r;
    i = byte_cnt;
    if (byte_cnt <= MaxRequestBytes) byte_cnt++;
    if (c == 0) flags[F_NUL] = 1;
    parse_in(c, i);
    if (!last) return;
    if (flags[F_NUL] || byte_cnt > MaxRequestBytes) st = ST_NOT_OURS;
    else case (phase)
      P_METHOD, P_OTHER_SEED, P_PREFIX: st = ST_NOT_OURS;
      P_PATH, P_QUERY, P_VERSION:       st = ST_NOT_FOUND;
      P_NAME, P_VALUE, P_DONE:          st = ST_OK;
      default:                          st = outc;
    endcase
    r = reject_result(st);
    if (st == ST_OK) begin
      full = '0;
      for (int k = 0; k < RootChars; k++) full = {full[5*RootChars-6:0], root_sym[k]};
      r.root = full[5*RootChars-1:3];
      r.head_only = flags[F_HEAD];
      r.none_match_hit = flags[F_INM];
      r.range_first = keep_first;
      r.range_last = keep_last;
    end
    if (fixed_status >= 0) r = reject_result(fixed_status[1:0]);
    pending_results.push_back(r);
    clear_parser();
  endtask

  // ---- stimulus building ----
  task automatic add_bytes(u8 bq[$], int fixed_status, bit pause);
    req_byte_t it;
    foreach (bq[k]) begin
      it.data = bq[k];
      it.last = (k == bq.size() - 1);
      it.fixed_status = it.last ? fixed_status : -1;
      it.pause = pause && (k == 0);
      byte_stream.push_back(it);
    end
  endtask

  task automatic add_text(string s, int fixed_status, int zero_at);
    u8 bq[$];
    for (int k = 0; k < s.len(); k++) bq.push_back((k == zero_at) ? 8'h00 : u8'(s[k]));
    add_bytes(bq, fixed_status, 0);
  endtask

  function automatic string mixed_case(string s);
    string o;
    u8 c;
    o = s;
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      if ($urandom_range(0, 2) == 0) begin
        if (c >= "a" && c <= "z") o[k] = c - 8'd32;
        else if (c >= "A" && c <= "Z") o[k] = c + 8'd32;
      end
    end
    return o;
  endfunction

  function automatic string rand_num();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '1;
      1: v = 0;
      2: v = {$urandom, $urandom};
      default: v = $urandom_range(0, 999);
    endcase
    return $sformatf("%0d", v);
  endfunction

  function automatic string ws_run();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, ($urandom_range(0, 1) ? " " : "\t")};
    return s;
  endfunction

  function automatic string range_value();
    case ($urandom_range(0, 9))
      0: return {"bytes=", rand_num(), "-"};
      1: return "bytes=900-3";
      2: return {"bytes=-", rand_num()};
      3: return "bytes=1-2,5-9";
      4: return {"bytes=", rand_num(), "-", rand_num(), "x"};
      5: return "bytes=18446744073709551616-";
      6: return {"bytes=", rand_num(), " -", rand_num()};
      default: return {"bytes=", rand_num(), "-", rand_num()};
    endcase
  endfunction

  task automatic build_request(output u8 bq[$]);
    string root, s, line, eol;
    int n;
    root = "";
    for (int k = 0; k < RootChars; k++) root = {root, string'(sym_char($urandom_range(0, 31)))};
    case ($urandom_range(0, 19))
      0: root[$urandom_range(0, RootChars - 1)] = "a" + $urandom_range(0, 25);
      1: root[$urandom_range(0, RootChars - 1)] = "1";
      2: root = root.substr(0, RootChars - 2);
      3: root = {root, "A"};
      default: ;
    endcase
    case ($urandom_range(0, 19))
      0, 1: s = "POST ";
      2:    s = "OPTIONS ";
      3:    s = "Get ";
      default: s = $urandom_range(0, 1) ? "GET " : "HEAD ";
    endcase
    s = {s, ($urandom_range(0, 19) == 0) ? "/seeD/" : "/seed/", root};
    if ($urandom_range(0, 4) == 0) begin
      s = {s, "?"};
      repeat ($urandom_range(0, 8)) s = {s, string'(u8'($urandom_range(8'h21, 8'h7e)))};
      if ($urandom_range(0, 19) == 0) s = {s, "\r"};
    end
    s = {s, " HTTP/1.", ($urandom_range(0, 19) == 0) ? "2" : ($urandom_range(0, 1) ? "1" : "0"),
         "\r\n"};
    n = $urandom_range(0, 4);
    repeat (n) begin
      eol = $urandom_range(0, 4) ? "\r\n" : "\n";
      case ($urandom_range(0, 5))
        0, 1: line = {mixed_case("Range"), ":", ws_run(), mixed_case(range_value()), ws_run()};
        2: begin
          case ($urandom_range(0, 4))
            0: line = "*";
            1: line = {"\"", root, "\""};
            2: line = {"W/\"", root, "\""};
            3: line = {"\"x\", \"", root, "\""};
            default: line = "* x";
          endcase
          line = {mixed_case("If-None-Match"), ":", ws_run(), line, ws_run()};
        end
        3: line = "Host: seed.example";
        4: line = "no colon here";
        default: line = "X-Range: bytes=1-2";
      endcase
      s = {s, line, eol};
    end
    case ($urandom_range(0, 9))
      0: ;
      1: s = {s, "Range: bytes=3-4"};
      2: s = {s, "\r\nRange: bytes=7-8\r\n"};
      default: s = {s, "\r\n"};
    endcase
    bq = {};
    for (int k = 0; k < s.len(); k++) bq.push_back(s[k]);
    if ($urandom_range(0, 29) == 0) bq[$urandom_range(0, bq.size() - 1)] = 8'h00;
  endtask

  task automatic build_stimulus();
    string ra, r7, rm, ok_line;
    u8 bq[$];
    int total, reqs, cut;
    ra = ""; r7 = "";
    for (int k = 0; k < RootChars; k++) begin
      ra = {ra, "A"};
      r7 = {r7, "7"};
    end
    rm = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567ABCDEFG";
    ok_line = {"GET /seed/", rm, " HTTP/1.1\r\n"};
    add_text({ok_line, "\r\n"}, -1, -1);
    add_text({"HEAD /seed/", r7, " HTTP/1.0\r\n\r\n"}, -1, -1);
    add_text({"GET /seed/", ra, " HTTP/1.0\r\nRange: bytes=0-18446744073709551615\r\n\r\n"},
             -1, -1);
    add_text({ok_line, "range:\t bytes=5- \r\n\r\n"}, -1, -1);
    add_text({ok_line, "Range: bytes=18446744073709551616-\r\n\r\n"}, -1, -1);
    add_text({ok_line, "Range: bytes=4-6\r\nRange: bytes=9-3\r\nRange: bytes=-5\r\n"}, -1, -1);
    add_text({ok_line, "If-None-Match: *\r\n\r\n"}, -1, -1);
    add_text({ok_line, "IF-NONE-MATCH: \"x\", \"", rm, "\"\r\n\r\n"}, -1, -1);
    add_text({"GET /seed/", rm, "?a=1&b HTTP/1.1\r\n\r\n"}, -1, -1);
    add_text({ok_line, "no colon\r\nRaNgE: bytes=1-2\r\n\r\nRange: bytes=3-4\r\n"}, -1, -1);
    add_text({ok_line, "Range: bytes=10-20\r\nRange: bytes=30-40"}, -1, -1);
    add_text({ok_line, "\r\n"}, ST_NOT_OURS, 20);
    add_text("POST /seed/x", ST_BAD_METHOD, -1);
    add_text("ABCDEFGHIJKLMNOPQRSTUVW /seed/", ST_BAD_METHOD, -1);
    add_text("ABCDEFGHIJKLMNOPQRSTUVWX /seed/", ST_NOT_OURS, -1);
    add_text("PUT /etc", ST_NOT_OURS, -1);
    add_text("GET /other/", ST_NOT_OURS, -1);
    add_text("G", ST_NOT_OURS, -1);
    add_text({"GET /seed/", rm.substr(0, 37), "a HTTP/1.1\r\n\r\n"}, ST_NOT_FOUND, -1);
    add_text({"GET /seed/", rm.substr(0, 37), " HTTP/1.1\r\n\r\n"}, ST_NOT_FOUND, -1);
    add_text({"GET /seed/", rm, " HTTP/1."}, ST_NOT_FOUND, -1);
    add_text({"GET /seed/", rm, "?a\rb HTTP/1.1\r\n\r\n"}, ST_NOT_FOUND, -1);
    add_text({"GET /seed/", rm, " HTTP/1.2\r\n\r\n"}, ST_NOT_FOUND, -1);
    // over-long request
    bq = {};
    for (int k = 0; k < ok_line.len(); k++) bq.push_back(ok_line[k]);
    repeat (MaxRequestBytes) bq.push_back("a");
    bq.push_back(CH_CR); bq.push_back(CH_LF);
    add_bytes(bq, ST_NOT_OURS, 0);

    total = 0;
    reqs = 0;
    while (total < 1150 || reqs < 48) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          bq = {};
          repeat ($urandom_range(1, 30)) bq.push_back($urandom_range(0, 255));
        end
        3, 4: begin
          build_request(bq);
          cut = $urandom_range(1, bq.size());
          while (bq.size() > cut) void'(bq.pop_back());
        end
        default: build_request(bq);
      endcase
      add_bytes(bq, -1, (reqs == 0 || reqs == 25));
      total += bq.size();
      reqs++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_bytes();
    int g, calm;
    req_byte_t it;
    calm = 0;
    foreach (byte_stream[n]) begin
      it = byte_stream[n];
      if (it.pause) begin
        s_tvalid <= 0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (calm > 0) begin
        calm--;
        g = 0;
      end else begin
        g = pick_gap();
        if ($urandom_range(0, 499) == 0) calm = 300;
      end
      if (g > 0) begin
        s_tvalid <= 0;
        repeat (g) @(posedge clk);
      end
      s_tvalid <= 1;
      s_tdata  <= it.data;
      s_tlast  <= it.last;
      @(negedge clk);
      while (!s_tready) @(negedge clk);
      @(posedge clk);
      classify_byte(it.data, it.last, it.fixed_status);
    end
    s_tvalid <= 0;
  endtask

  task automatic drive_ready();
    int gap, calm;
    bit held;
    gap = 0; calm = 0; held = 0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 15) begin
        // long hold-off so the block backs up onto its input
        held = 1;
        m_tready <= 0;
        repeat (300) @(posedge clk);
        m_tready <= 1;
      end else if (calm > 0) begin
        calm--;
        m_tready <= 1;
      end else if (gap > 0) begin
        gap--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if ($urandom_range(0, 799) == 0) calm = 200;
        else if ($urandom_range(0, 3) == 0) gap = pick_gap();
      end
    end
  endtask

  // result side is stable at the falling edge; acceptance follows at the next rise
  always @(negedge clk) begin
    hsrc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("status expected %0d actual %0d", want.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[2] !== want.head_only) begin
          $error("head_only expected %0d actual %0d", want.head_only, m_tdata[2]);
          errors++;
        end
        if (m_tdata[3] !== want.none_match_hit) begin
          $error("none_match_hit expected %0d actual %0d", want.none_match_hit, m_tdata[3]);
          errors++;
        end
        if (m_tdata[67:4] !== want.range_first) begin
          $error("range_first expected %h actual %h", want.range_first, m_tdata[67:4]);
          errors++;
        end
        if (m_tdata[131:68] !== want.range_last) begin
          $error("range_last expected %h actual %h", want.range_last, m_tdata[131:68]);
          errors++;
        end
        if (m_tdata[195:132] !== want.root[191:128]) begin
          $error("root_word_high expected %h actual %h", want.root[191:128], m_tdata[195:132]);
          errors++;
        end
        if (m_tdata[259:196] !== want.root[127:64]) begin
          $error("root_word_mid expected %h actual %h", want.root[127:64], m_tdata[259:196]);
          errors++;
        end
        if (m_tdata[323:260] !== want.root[63:0]) begin
          $error("root_word_low expected %h actual %h", want.root[63:0], m_tdata[323:260]);
          errors++;
        end
      end
    end
  end

  initial begin
    rst      <= 1;
    s_tvalid <= 0;
    s_tdata  <= 0;
    s_tlast  <= 0;
    m_tready <= 0;
    clear_parser();
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 0;
    fork
      send_bytes();
      drive_ready();
    join_any
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results.size() == 0 && errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
